/* rtl/core/lif_pkg.sv */
// Shared types and constants for the LIF neuron population step block.
package lif_pkg;

  // Register indexes of the configuration channel.
  localparam logic [2:0] REG_MEM_GAIN  = 3'd0;
  localparam logic [2:0] REG_SYN_GAIN  = 3'd1;
  localparam logic [2:0] REG_LEAK_V    = 3'd2;
  localparam logic [2:0] REG_THRESH_V  = 3'd3;
  localparam logic [2:0] REG_RESET_V   = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // Reset values of the configuration registers.
  localparam logic [15:0]        MEM_GAIN_RST = 16'd6554;
  localparam logic [15:0]        SYN_GAIN_RST = 16'd13107;
  localparam logic signed [31:0] LEAK_V_RST   = 32'sd0;
  localparam logic signed [31:0] THRESH_V_RST = 32'sd65536;
  localparam logic signed [31:0] RESET_V_RST  = 32'sd0;

  typedef struct packed {
    logic [15:0]        mem_gain;
    logic [15:0]        syn_gain;
    logic signed [31:0] leak_v;
    logic signed [31:0] thresh_v;
    logic signed [31:0] reset_v;
  } cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic [7:0]         idx;
    logic signed [31:0] cur;
    logic               in_range;
  } item_t;

endpackage

/* rtl/core/lif_cfg_regs.sv */
// Configuration register file of the LIF neuron population step block.
module lif_cfg_regs
  import lif_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mem_gain <= MEM_GAIN_RST;
      cfg.syn_gain <= SYN_GAIN_RST;
      cfg.leak_v   <= LEAK_V_RST;
      cfg.thresh_v <= THRESH_V_RST;
      cfg.reset_v  <= RESET_V_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MEM_GAIN: cfg.mem_gain <= cfg_data[15:0];
        REG_SYN_GAIN: cfg.syn_gain <= cfg_data[15:0];
        REG_LEAK_V:   cfg.leak_v   <= cfg_data;
        REG_THRESH_V: cfg.thresh_v <= cfg_data;
        REG_RESET_V:  cfg.reset_v  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/lif_front.sv */
// Front end: accepts input requests, checks the neuron index and queues them.
module lif_front
  import lif_pkg::*;
#(
  parameter int NEURONS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  output logic                 q_valid,
  output item_t                q_item,
  input  logic                 q_pop
);

  item_t           q_mem [QDEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QCW-1:0]  count;
  item_t           new_item;
  logic            push;

  // An index beyond the population runs on zero state and is never stored.
  always_comb begin
    new_item.idx      = s_tdata[7:0];
    new_item.cur      = s_tdata[39:8];
    new_item.in_range = ({24'd0, s_tdata[7:0]} < 32'(NEURONS));
  end

  assign s_tready = (count != QCW'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lif_back.sv */
// Back end: neuron state store and the pipelined Euler step with write-back.
module lif_back
  import lif_pkg::*;
#(
  parameter int NEURONS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int DEPTH = (NEURONS < 256) ? NEURONS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -36'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // State store: membrane voltage in the upper word, synaptic current below.
  logic [63:0]      store [DEPTH];
  logic [DEPTH-1:0] live;
  logic [63:0]      rd_word;
  logic             rd_live;

  logic advance;
  logic hazard;
  logic wr_en;
  logic [AW-1:0] q_addr;

  // Stage 1: stored state read, item payload.
  logic               p1_valid;
  item_t              p1_item;
  // Stage 2: current jump.
  logic               p2_valid;
  item_t              p2_item;
  logic signed [31:0] p2_v;
  logic signed [31:0] p2_jump;
  // Stage 3: membrane drive.
  logic               p3_valid;
  item_t              p3_item;
  logic signed [31:0] p3_v;
  logic signed [31:0] p3_jump;
  logic signed [33:0] p3_drive;
  // Stage 4: gain products.
  logic               p4_valid;
  item_t              p4_item;
  logic signed [31:0] p4_v;
  logic signed [31:0] p4_jump;
  logic signed [50:0] p4_pm;
  logic signed [48:0] p4_ps;
  // Output register.
  logic               o_valid;
  logic [7:0]         o_idx;
  logic               o_spike;
  logic signed [31:0] o_v;
  logic signed [31:0] o_i;

  logic signed [31:0] p1_v;
  logic signed [31:0] p1_i;
  logic signed [32:0] jump_sum;
  logic signed [33:0] drive;
  logic signed [35:0] v_sum;
  logic signed [35:0] i_sum;
  logic signed [31:0] v_dec;
  logic signed [31:0] i_new;
  logic               fire;
  logic signed [31:0] v_new;

  assign advance = !o_valid || m_tready;
  assign q_addr  = q_item.idx[AW-1:0];

  // A neuron already in the pipeline must finish its write-back first.
  always_comb begin
    hazard = 1'b0;
    if (q_item.in_range) begin
      if (p1_valid && p1_item.in_range && (p1_item.idx == q_item.idx)) hazard = 1'b1;
      if (p2_valid && p2_item.in_range && (p2_item.idx == q_item.idx)) hazard = 1'b1;
      if (p3_valid && p3_item.in_range && (p3_item.idx == q_item.idx)) hazard = 1'b1;
      if (p4_valid && p4_item.in_range && (p4_item.idx == q_item.idx)) hazard = 1'b1;
    end
  end

  assign q_pop = q_valid && advance && !hazard;

  always_comb begin
    if (p1_item.in_range && rd_live) begin
      p1_v = rd_word[63:32];
      p1_i = rd_word[31:0];
    end else begin
      p1_v = '0;
      p1_i = '0;
    end
    jump_sum = 33'(p1_i) + 33'(p1_item.cur);
    drive    = 34'(cfg.leak_v) - 34'(p2_v) + 34'(p2_jump);
    v_sum    = 36'(p4_v) + 36'($signed(p4_pm[50:16]));
    i_sum    = 36'(p4_jump) - 36'($signed(p4_ps[48:16]));
    v_dec    = sat36(v_sum);
    i_new    = sat36(i_sum);
    fire     = v_dec > cfg.thresh_v;
    v_new    = fire ? cfg.reset_v : v_dec;
  end

  assign wr_en = advance && p4_valid && p4_item.in_range;

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_word <= store[q_addr];
    end
    if (wr_en) begin
      store[p4_item.idx[AW-1:0]] <= {v_new, i_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      rd_live <= 1'b0;
    end else begin
      if (advance) begin
        rd_live <= live[q_addr];
      end
      if (wr_en) begin
        live[p4_item.idx[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (advance) begin
      p1_valid <= q_pop;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      o_valid  <= p4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_item  <= q_item;
      p2_item  <= p1_item;
      p2_v     <= p1_v;
      p2_jump  <= sat36(36'(jump_sum));
      p3_item  <= p2_item;
      p3_v     <= p2_v;
      p3_jump  <= p2_jump;
      p3_drive <= drive;
      p4_item  <= p3_item;
      p4_v     <= p3_v;
      p4_jump  <= p3_jump;
      p4_pm    <= 51'(p3_drive) * 51'($signed({1'b0, cfg.mem_gain}));
      p4_ps    <= 49'(p3_jump) * 49'($signed({1'b0, cfg.syn_gain}));
      o_idx    <= p4_item.idx;
      o_spike  <= fire;
      o_v      <= v_new;
      o_i      <= i_new;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'd0, o_i, o_v, o_spike, o_idx};

endmodule

/* rtl/core/lif_neuron_population_step_top.sv */
// Top level of the LIF neuron population step block.
//
// Each input request names a neuron and carries its input current for one
// time step; the block runs one Euler step of a leaky integrate-and-fire
// neuron and returns one result request with the new membrane voltage, the
// new synaptic current and the spike flag. Per-neuron state lives in an
// on-chip store that reads as zero after reset, so no clearing pass is needed.
// Requests with an index beyond the population run on zero state and are not
// stored.
//
// Throughput is one request per cycle while no request waits on an earlier
// write-back and the output is not stalled. The state store is read and
// written back through a five-stage pipeline (read, jump, drive, gain
// products, saturate and fire); a request for a neuron that is still in that
// pipeline waits until the earlier write-back.
//
// A four-entry queue parts the input side from the pipeline, so the input
// keeps taking requests while a result waits on m_tready; a stalled output
// freezes the pipeline, and s_tready falls once the queue is full.
// Reset is synchronous and clears the queue, the pipeline and the state.
// Configuration writes are taken every cycle and must occur only when idle.
module lif_neuron_population_step_top
  import lif_pkg::*;
#(
  parameter int NEURONS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [7:0] neuron_index, [39:8] input_current
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] neuron_out, [8] spike, [40:9] membrane_out, [72:41] current_out,
  // [79:73] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  lif_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lif_front #(.NEURONS(NEURONS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lif_back #(.NEURONS(NEURONS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Requests accepted but not yet delivered: queue plus pipeline plus output.
  localparam logic [3:0] MAX_PENDING = 4'(QDEPTH + 5);

  logic [3:0] pending;
  logic [3:0] pending_next;

  always_comb begin
    pending_next = pending;
    if (s_tvalid && s_tready) pending_next = pending_next + 1'b1;
    if (m_tvalid && m_tready) pending_next = pending_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != '0))
    else $error("result offered with no request in flight");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= MAX_PENDING)
    else $error("more requests in flight than the block can hold");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (pending == MAX_PENDING) |-> !s_tready)
    else $error("input taken while queue and pipeline are full");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

endmodule

/* verif/lif_step_checker.sv */
`timescale 1ns / 100ps
// Checker for the LIF population step block: keeps its own neuron state and compares every result.
module lif_step_checker
  import lif_pkg::*;
#(
  parameter int NEURONS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    open_steps,
  output int                    results_checked,
  output int                    spikes_seen
);

  typedef struct packed {
    logic [7:0]         neuron;
    logic               spike;
    logic signed [31:0] membrane;
    logic signed [31:0] current;
  } step_result_t;

  localparam longint signed Q_MAX = 64'sd2147483647;
  localparam longint signed Q_MIN = -64'sd2147483648;

  logic signed [31:0] membrane_mem [NEURONS];
  logic signed [31:0] current_mem  [NEURONS];
  cfg_t               settings;
  step_result_t       expected_steps [$];
  step_result_t       got_step;
  step_result_t       want_step;
  int                 err_cnt   = 0;
  int                 res_cnt   = 0;
  int                 spike_cnt = 0;

  function automatic logic signed [31:0] clamp_q16(input longint signed x);
    if (x > Q_MAX) return 32'sh7FFF_FFFF;
    if (x < Q_MIN) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // One Euler step on the mirrored state; the write-back happens here too, so
  // back-to-back requests for one neuron see each other in order.
  function automatic step_result_t euler_step(input logic [7:0] idx,
                                              input logic signed [31:0] stim);
    logic          in_pop;
    longint signed v;
    longint signed i;
    longint signed jump;
    longint signed drive;
    longint signed vdec;
    longint signed inew;
    step_result_t  r;
    in_pop = idx < NEURONS;
    v      = in_pop ? longint'(membrane_mem[idx]) : 64'sd0;
    i      = in_pop ? longint'(current_mem[idx]) : 64'sd0;
    jump   = clamp_q16(i + longint'(stim));
    drive  = (longint'($signed(settings.leak_v)) - v) + jump;
    vdec   = clamp_q16(v + ((drive * longint'({48'd0, settings.mem_gain})) >>> 16));
    inew   = clamp_q16(jump - ((jump * longint'({48'd0, settings.syn_gain})) >>> 16));
    r.neuron   = idx;
    r.spike    = vdec > longint'($signed(settings.thresh_v));
    r.membrane = r.spike ? settings.reset_v : vdec[31:0];
    r.current  = inew[31:0];
    if (in_pop) begin
      membrane_mem[idx] = r.membrane;
      current_mem[idx]  = r.current;
    end
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [7:0] neuron,
                            input logic signed [63:0] want, input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: neuron %0d %s expected %0d, got %0d", $time, neuron, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NEURONS; n++) begin
        membrane_mem[n] = '0;
        current_mem[n]  = '0;
      end
      settings = '{MEM_GAIN_RST, SYN_GAIN_RST, LEAK_V_RST, THRESH_V_RST, RESET_V_RST};
      expected_steps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MEM_GAIN: settings.mem_gain = cfg_data[15:0];
          REG_SYN_GAIN: settings.syn_gain = cfg_data[15:0];
          REG_LEAK_V:   settings.leak_v   = cfg_data;
          REG_THRESH_V: settings.thresh_v = cfg_data;
          REG_RESET_V:  settings.reset_v  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_steps.insert(expected_steps.size(), euler_step(s_tdata[7:0], s_tdata[39:8]));
      end
      if (m_tvalid && m_tready) begin
        got_step = {m_tdata[7:0], m_tdata[8], m_tdata[40:9], m_tdata[72:41]};
        res_cnt++;
        if (got_step.spike === 1'b1) spike_cnt++;
        if (expected_steps.size() == 0) begin
          $display("%0t: result for neuron %0d with no request outstanding, expected none",
                   $time, got_step.neuron);
          err_cnt++;
        end else begin
          want_step = expected_steps.pop_front();
          flag_field("neuron_out", want_step.neuron, want_step.neuron, got_step.neuron);
          flag_field("spike", want_step.neuron, want_step.spike, got_step.spike);
          flag_field("membrane_out", want_step.neuron, want_step.membrane, got_step.membrane);
          flag_field("current_out", want_step.neuron, want_step.current, got_step.current);
        end
      end
    end
    errors          <= err_cnt;
    open_steps      <= expected_steps.size();
    results_checked <= res_cnt;
    spikes_seen     <= spike_cnt;
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Testbench top for the LIF neuron population step block: stimulus, pacing and verdict.
module testbench
  import lif_pkg::*;
();

  localparam int NEURONS       = 256;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_STEPS = 325;
  // The pipeline is five stages deep behind a four-entry queue, so this drain
  // time comfortably covers anything still in flight.
  localparam int DRAIN_CYCLES  = 20;

  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [31:0] Q_POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_NEG_MAX = 32'sh8000_0000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // [7:0] neuron_index, [39:8] input_current
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // [7:0] neuron_out, [8] spike, [40:9] membrane_out, [72:41] current_out, [79:73] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int steps_sent     = 0;
  int directed_steps = 0;
  int reg_writes     = 0;
  int settings_used  = 1;

  int errors;
  int open_steps;
  int results_checked;
  int spikes_seen;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lif_neuron_population_step_top #(
    .NEURONS(NEURONS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  lif_step_checker #(
    .NEURONS(NEURONS)
  ) checker_inst (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .open_steps     (open_steps),
    .results_checked(results_checked),
    .spikes_seen    (spikes_seen)
  );

  // The result side stalls at random. Everything the testbench drives changes
  // on the falling edge, away from the rising edge where the block samples it.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog. A correct run finishes well inside this limit even with the
  // heaviest stalls.
  initial begin
    #(5_000_000);
    $display("timeout: the block stopped making progress");
    $display("status: fail");
    $finish;
  end

  // Offers one request and returns at the falling edge after it was taken.
  // Idle cycles, if any, come before the request; s_tvalid stays high from
  // one request to the next when no idle cycle falls between them.
  task automatic send_step(input logic [7:0] neuron, input logic signed [31:0] stim);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {stim, neuron};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    steps_sent++;
  endtask

  // The request line is already low here. Waits until every result is back
  // and then waits out the drain time so the pipeline is certainly empty.
  task automatic wait_idle();
    @(negedge clk);
    while (open_steps != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    reg_writes++;
  endtask

  // Loads a full register set. The gains go out with random junk in the upper
  // half of the data word, which the block must drop.
  task automatic load_settings(input logic [15:0] mem_gain, input logic [15:0] syn_gain,
                               input logic signed [31:0] leak_v,
                               input logic signed [31:0] thresh_v,
                               input logic signed [31:0] reset_v);
    write_reg(REG_MEM_GAIN, {16'($urandom()), mem_gain});
    write_reg(REG_SYN_GAIN, {16'($urandom()), syn_gain});
    write_reg(REG_LEAK_V, leak_v);
    write_reg(REG_THRESH_V, thresh_v);
    write_reg(REG_RESET_V, reset_v);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Most requests hit a handful of neurons so that repeats land inside the
  // pipeline and exercise the hazard stall; the rest spread over all 256.
  function automatic logic [7:0] pick_neuron();
    if ($urandom_range(99) < 70) return 8'($urandom_range(7));
    return 8'($urandom_range(NEURONS - 1));
  endfunction

  // Mostly currents of a few units around zero, so that spikes come often
  // under ordinary thresholds, plus raw 32-bit values and the two extremes.
  function automatic logic signed [31:0] pick_current();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? Q_POS_MAX : Q_NEG_MAX;
      1, 2:    return $urandom();
      default: return $signed($urandom_range(6 * 65536)) - 2 * Q_ONE;
    endcase
  endfunction

  // One random segment. Halfway through, the sender holds off until every
  // result is back, so the block also starts again from an empty pipeline.
  task automatic run_segment(input int count);
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (open_steps != 0) @(negedge clk);
      end
      send_step(pick_neuron(), pick_current());
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, on the reset register values (gains about 0.1 and 0.2,
    // threshold 1.0, leak and reset level at zero).
    send_idle_pct = 8;
    recv_idle_pct = 81;
    // The same neuron back to back: each step waits for the write-back of the one
    // before it and then reads what that one wrote, until it fires.
    repeat (6) send_step(8'd0, 2 * Q_ONE);
    // From rest, this current lands the membrane exactly on the threshold,
    // which must not fire; the next one lands just above it and must.
    send_step(8'd2, 32'sd655325);
    send_step(8'd3, 32'sd655335);
    // Largest positive and negative currents: the jump saturates on repeated steps
    // and the stored current stays at the same value, below the limit.
    repeat (3) send_step(8'd255, Q_POS_MAX);
    repeat (3) send_step(8'd128, Q_NEG_MAX);
    // A tiny negative current: the products round toward minus infinity.
    send_step(8'd9, -32'sd1);
    send_step(8'd9, 32'sd0);
    // Two neurons interleaved, so each repeat sits two slots apart.
    repeat (2) begin
      send_step(8'd4, Q_ONE + Q_ONE / 2);
      send_step(8'd5, -Q_ONE);
    end
    // Repeats three apart, and a neuron that sees no input at all.
    send_step(8'd6, 3 * Q_ONE);
    send_step(8'd7, Q_ONE);
    send_step(8'd1, 32'sd0);
    send_step(8'd6, 3 * Q_ONE);
    s_tvalid <= 1'b0;
    directed_steps = steps_sent;
    wait_idle();

    // Random part: each segment runs under its own register set, written
    // while the block is idle. Segments pair up on the three pacing modes:
    // mostly stalled receiver, then mostly idle sender, then no gaps at all.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          // Writes to the unused register indexes must change nothing.
          for (int r = REG_RESET_V + 1; r < 2 ** CFG_IDX_W; r++) begin
            write_reg(r[CFG_IDX_W-1:0], $urandom());
          end
          // Everything at its top: full-scale gains, leak and threshold at
          // the positive limit, reset level at the negative one.
          load_settings(16'hFFFF, 16'hFFFF, Q_POS_MAX, Q_POS_MAX, Q_NEG_MAX);
        end
        1: load_settings(16'h0000, 16'h0000, Q_NEG_MAX, Q_NEG_MAX, Q_POS_MAX);
        2: load_settings(16'd6554, 16'd13107, 32'sd0, Q_ONE, -Q_ONE / 2);
        3, 4: begin
          load_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        $signed($urandom_range(4 * 65536)) - 2 * Q_ONE,
                        $signed($urandom_range(4 * 65536)),
                        $signed($urandom_range(2 * 65536)) - Q_ONE);
        end
        default: begin
          load_settings(16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                        $urandom());
        end
      endcase
      send_idle_pct = (seg < 2) ? 8 : (seg < 4) ? 81 : 0;
      recv_idle_pct = (seg < 2) ? 81 : (seg < 4) ? 8 : 0;
      @(negedge clk);
      run_segment(SEGMENT_STEPS);
      wait_idle();
    end

    $display("%0d neuron steps sent (%0d directed), %0d results checked, %0d spikes",
             steps_sent, directed_steps, results_checked, spikes_seen);
    $display("%0d register writes over %0d register sets, including both gain extremes",
             reg_writes, settings_used);
    if (open_steps != 0) begin
      $display("%0t: %0d expected results never arrived", $time, open_steps);
    end
    if (errors == 0 && open_steps == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
